FILE: src/bbi2c_pkg.sv
// Package for the bit-banged I2C register master.
// Holds the transfer payload types, the bus segment table and the sequencer codes.
// No dependencies.
package bbi2c_pkg;

    localparam int UNIT_W  = 16;
    localparam int STEP_W  = 5;
    localparam int UNITS_W = 3;
    // longest segment is 6 units of at most 65535 ticks
    localparam int WAIT_W  = 19;

    // sequencer steps: 0 idle, 1-3 start, 4-11 send bit + ack,
    // 12-18 receive bit + master ack, 19-21 stop
    localparam logic [STEP_W-1:0] SEG_IDLE        = 5'd0;
    localparam logic [STEP_W-1:0] SEG_START       = 5'd1;
    localparam logic [STEP_W-1:0] SEG_START_END   = 5'd3;
    localparam logic [STEP_W-1:0] SEG_SEND        = 5'd4;
    localparam logic [STEP_W-1:0] SEG_SEND_END    = 5'd7;
    localparam logic [STEP_W-1:0] SEG_ACK_SAMPLE  = 5'd9;
    localparam logic [STEP_W-1:0] SEG_ACK_HOLD    = 5'd10;
    localparam logic [STEP_W-1:0] SEG_ACK_END     = 5'd11;
    localparam logic [STEP_W-1:0] SEG_RECV        = 5'd12;
    localparam logic [STEP_W-1:0] SEG_RECV_SAMPLE = 5'd13;
    localparam logic [STEP_W-1:0] SEG_RECV_HOLD   = 5'd14;
    localparam logic [STEP_W-1:0] SEG_RECV_END    = 5'd15;
    localparam logic [STEP_W-1:0] SEG_MACK        = 5'd16;
    localparam logic [STEP_W-1:0] SEG_MACK_END    = 5'd18;
    localparam logic [STEP_W-1:0] SEG_STOP        = 5'd19;
    localparam logic [STEP_W-1:0] SEG_STOP_END    = 5'd21;

    localparam logic [STEP_W-1:0] SEG_ACK_REL     = 5'd8;

    // how a segment sets SDA on entry
    localparam logic [2:0] SDA_KEEP = 3'd0;
    localparam logic [2:0] SDA_LOW  = 3'd1;
    localparam logic [2:0] SDA_HIGH = 3'd2;
    localparam logic [2:0] SDA_BIT  = 3'd3;
    localparam logic [2:0] SDA_MACK = 3'd4;

    // bus operations of a command
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_SEND  = 2'd1;
    localparam logic [1:0] OP_RECV  = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    // operation index within a command
    localparam logic [2:0] STG_START   = 3'd0;
    localparam logic [2:0] STG_ADDR    = 3'd1;
    localparam logic [2:0] STG_REG     = 3'd2;
    localparam logic [2:0] STG_THIRD   = 3'd3;
    localparam logic [2:0] STG_FOURTH  = 3'd4;
    localparam logic [2:0] STG_RD_BYTE0 = 3'd5;
    localparam logic [2:0] STG_RD_BYTE1 = 3'd6;

    localparam logic [7:0] MSB_MASK = 8'h80;

    typedef struct packed {
        logic       cmd_valid;
        logic       operation;
        logic [1:0] byte_count;
        logic [7:0] chip_address;
        logic [7:0] register_address;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic       sda_in;
    } t_cmd_item;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic        nack_error;
        logic [15:0] read_bytes;
    } t_res_item;

    typedef struct packed {
        logic       scl;
        logic [2:0] sda_mode;
        logic       drv;
        logic [UNITS_W-1:0] units;
    } t_seg;

    typedef struct packed {
        logic       drv;
        logic       sda;
        logic       scl;
    } t_pins;

    typedef struct packed {
        logic       rd;
        logic       two;
        logic [7:0] chip;
        logic [7:0] reg_addr;
        logic [7:0] data0;
        logic [7:0] data1;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] val;
    } t_op;

    function automatic t_seg seg_table(input logic [STEP_W-1:0] step);
        t_seg d;
        unique case (step)
            5'd0:    d = '{1'b1, SDA_KEEP, 1'b1, 3'd1};
            5'd1:    d = '{1'b1, SDA_HIGH, 1'b1, 3'd1};
            5'd2:    d = '{1'b1, SDA_LOW,  1'b1, 3'd2};
            5'd3:    d = '{1'b0, SDA_KEEP, 1'b1, 3'd2};
            5'd4:    d = '{1'b0, SDA_KEEP, 1'b1, 3'd2};
            5'd5:    d = '{1'b0, SDA_BIT,  1'b1, 3'd2};
            5'd6:    d = '{1'b1, SDA_KEEP, 1'b1, 3'd6};
            5'd7:    d = '{1'b0, SDA_KEEP, 1'b1, 3'd2};
            5'd8:    d = '{1'b0, SDA_KEEP, 1'b0, 3'd4};
            5'd9:    d = '{1'b1, SDA_KEEP, 1'b0, 3'd4};
            5'd10:   d = '{1'b1, SDA_KEEP, 1'b0, 3'd2};
            5'd11:   d = '{1'b0, SDA_KEEP, 1'b0, 3'd2};
            5'd12:   d = '{1'b0, SDA_KEEP, 1'b0, 3'd2};
            5'd13:   d = '{1'b1, SDA_KEEP, 1'b0, 3'd4};
            5'd14:   d = '{1'b1, SDA_KEEP, 1'b0, 3'd2};
            5'd15:   d = '{1'b0, SDA_KEEP, 1'b0, 3'd4};
            5'd16:   d = '{1'b0, SDA_MACK, 1'b1, 3'd4};
            5'd17:   d = '{1'b1, SDA_KEEP, 1'b1, 3'd6};
            5'd18:   d = '{1'b0, SDA_KEEP, 1'b1, 3'd4};
            5'd19:   d = '{1'b0, SDA_LOW,  1'b1, 3'd1};
            5'd20:   d = '{1'b1, SDA_KEEP, 1'b1, 3'd2};
            5'd21:   d = '{1'b1, SDA_HIGH, 1'b1, 3'd2};
            default: d = '{1'b1, SDA_KEEP, 1'b1, 3'd1};
        endcase
        return d;
    endfunction

endpackage

FILE: src/bbi2c_stream_if.sv
// Valid/ready channel carrying one payload item per transfer.
// Payload type is set by the instantiating level from bbi2c_pkg types.
interface bbi2c_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/bit_banged_i2c_register_master.sv
// Bit-banged I2C register master: one tick in, one pin/status result out.
// Depends on bbi2c_pkg and bbi2c_stream_if.

// Every transfer on i_cmd is one timing tick and yields exactly one result on o_res:
// the SCL level, SDA level and drive enable, busy, a one-tick done pulse with
// nack_error, and the bytes read so far. A tick with cmd_valid set starts a register
// write or read (one or two data bytes) when the sequencer is idle and is ignored
// otherwise. One tick is taken every clock while o_res is not stalled; a tick passes an
// input register and the sequencer update to reach the result register, which offers
// its result until o_res takes it. Each bus segment lasts its unit count (1 to 6) times
// unit_ticks ticks (zero counts as one); i_cfg_wdata written with i_cfg_we sets
// unit_ticks and should only change while no command is running.
module bit_banged_i2c_register_master (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bbi2c_pkg::UNIT_W-1:0] i_cfg_wdata,
    bbi2c_stream_if.sink                 i_cmd,
    bbi2c_stream_if.source               o_res
);

    localparam int STEP_W = bbi2c_pkg::STEP_W;
    localparam int WAIT_W = bbi2c_pkg::WAIT_W;

    logic [bbi2c_pkg::UNIT_W-1:0] r_unit;

    logic                  r_in_valid;
    bbi2c_pkg::t_cmd_item  r_in;
    logic                  r_out_valid;
    bbi2c_pkg::t_res_item  r_res;
    logic                  advance;

    logic [STEP_W-1:0]     r_step, n_step;
    logic [WAIT_W-1:0]     r_wait, n_wait;
    logic [2:0]            r_bit, n_bit;
    logic [2:0]            r_stage, n_stage;
    logic [7:0]            r_shift, n_shift;
    logic [15:0]           r_captured, n_captured;
    bbi2c_pkg::t_cmd       r_cmd, n_cmd;
    bbi2c_pkg::t_pins      r_pins, n_pins;
    logic                  n_done, n_err;

    // operation at a given place of the command, with the byte it sends
    function automatic bbi2c_pkg::t_op op_at(input logic [2:0] stage,
                                             input bbi2c_pkg::t_cmd cmd);
        bbi2c_pkg::t_op op;
        op.kind = bbi2c_pkg::OP_STOP;
        op.val  = 8'h00;
        if (stage == bbi2c_pkg::STG_START) begin
            op.kind = bbi2c_pkg::OP_START;
        end else if (stage == bbi2c_pkg::STG_ADDR) begin
            op.kind = bbi2c_pkg::OP_SEND;
            op.val  = cmd.chip;
        end else if (stage == bbi2c_pkg::STG_REG) begin
            op.kind = bbi2c_pkg::OP_SEND;
            op.val  = cmd.reg_addr;
        end else if (!cmd.rd) begin
            if (stage == bbi2c_pkg::STG_THIRD) begin
                op.kind = bbi2c_pkg::OP_SEND;
                op.val  = cmd.data0;
            end else if (stage == bbi2c_pkg::STG_FOURTH && cmd.two) begin
                op.kind = bbi2c_pkg::OP_SEND;
                op.val  = cmd.data1;
            end
        end else begin
            if (stage == bbi2c_pkg::STG_THIRD) begin
                op.kind = bbi2c_pkg::OP_START;
            end else if (stage == bbi2c_pkg::STG_FOURTH) begin
                op.kind = bbi2c_pkg::OP_SEND;
                op.val  = cmd.chip + 8'd1;
            end else if (stage == bbi2c_pkg::STG_RD_BYTE0) begin
                op.kind = bbi2c_pkg::OP_RECV;
            end else if (stage == bbi2c_pkg::STG_RD_BYTE1 && cmd.two) begin
                op.kind = bbi2c_pkg::OP_RECV;
            end
        end
        return op;
    endfunction

    // handshake: input register feeds the result register
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_res;

    always_comb begin
        logic [bbi2c_pkg::UNIT_W-1:0] unit_eff;
        bbi2c_pkg::t_seg              cur_d;
        bbi2c_pkg::t_seg              ent_d;
        bbi2c_pkg::t_op               op;
        logic [WAIT_W-1:0]            seg_len;
        logic [WAIT_W-1:0]            wait_inc;
        logic                         start_en;
        logic                         enter_en;
        logic [STEP_W-1:0]            enter_seg;
        logic                         sda;

        n_step     = r_step;
        n_wait     = r_wait;
        n_bit      = r_bit;
        n_stage    = r_stage;
        n_shift    = r_shift;
        n_captured = r_captured;
        n_cmd      = r_cmd;
        n_pins     = r_pins;
        n_done     = 1'b0;
        n_err      = 1'b0;
        start_en   = 1'b0;
        enter_en   = 1'b0;
        enter_seg  = r_step;

        unit_eff = (r_unit == '0) ? bbi2c_pkg::UNIT_W'(1) : r_unit;
        cur_d    = bbi2c_pkg::seg_table(r_step);
        seg_len  = WAIT_W'(cur_d.units) * WAIT_W'(unit_eff);
        wait_inc = r_wait + WAIT_W'(1);

        if (r_step == bbi2c_pkg::SEG_IDLE) begin
            if (r_in.cmd_valid) begin
                n_cmd.rd       = r_in.operation;
                n_cmd.two      = r_in.byte_count[1];
                n_cmd.chip     = r_in.chip_address;
                n_cmd.reg_addr = r_in.register_address;
                n_cmd.data0    = r_in.first_data;
                n_cmd.data1    = r_in.second_data;
                n_captured     = '0;
                n_stage        = bbi2c_pkg::STG_START;
                start_en       = 1'b1;
            end
        end else begin
            n_wait = wait_inc;
            if (wait_inc >= seg_len) begin
                unique case (r_step)
                    bbi2c_pkg::SEG_START_END,
                    bbi2c_pkg::SEG_MACK_END: begin
                        n_stage  = r_stage + 3'd1;
                        start_en = 1'b1;
                    end
                    bbi2c_pkg::SEG_SEND_END: begin
                        n_shift  = {r_shift[6:0], 1'b0};
                        enter_en = 1'b1;
                        if (r_bit != 3'd7) begin
                            n_bit     = r_bit + 3'd1;
                            enter_seg = bbi2c_pkg::SEG_SEND;
                        end else begin
                            enter_seg = bbi2c_pkg::SEG_ACK_REL;
                        end
                    end
                    bbi2c_pkg::SEG_ACK_SAMPLE: begin
                        n_shift   = {7'd0, r_in.sda_in};
                        enter_en  = 1'b1;
                        enter_seg = bbi2c_pkg::SEG_ACK_HOLD;
                    end
                    bbi2c_pkg::SEG_ACK_END: begin
                        n_pins = '{drv: 1'b1, sda: 1'b1, scl: 1'b0};
                        if (r_shift[0]) begin
                            // slave NACK: abort without a stop
                            n_step = bbi2c_pkg::SEG_IDLE;
                            n_wait = '0;
                            n_done = 1'b1;
                            n_err  = 1'b1;
                        end else begin
                            n_stage  = r_stage + 3'd1;
                            start_en = 1'b1;
                        end
                    end
                    bbi2c_pkg::SEG_RECV_SAMPLE: begin
                        n_shift   = {r_shift[6:0], r_in.sda_in};
                        enter_en  = 1'b1;
                        enter_seg = bbi2c_pkg::SEG_RECV_HOLD;
                    end
                    bbi2c_pkg::SEG_RECV_END: begin
                        enter_en = 1'b1;
                        if (r_bit != 3'd7) begin
                            n_bit     = r_bit + 3'd1;
                            enter_seg = bbi2c_pkg::SEG_RECV;
                        end else begin
                            if (r_stage == bbi2c_pkg::STG_RD_BYTE0) begin
                                n_captured[7:0] = r_shift;
                            end else begin
                                n_captured[15:8] = r_shift;
                            end
                            n_pins    = '{drv: 1'b1, sda: 1'b1, scl: 1'b0};
                            enter_seg = bbi2c_pkg::SEG_MACK;
                        end
                    end
                    bbi2c_pkg::SEG_STOP_END: begin
                        n_step = bbi2c_pkg::SEG_IDLE;
                        n_wait = '0;
                        n_done = 1'b1;
                    end
                    default: begin
                        if (r_step < bbi2c_pkg::SEG_STOP_END) begin
                            enter_en  = 1'b1;
                            enter_seg = r_step + STEP_W'(1);
                        end else begin
                            n_step = bbi2c_pkg::SEG_IDLE;
                            n_wait = '0;
                        end
                    end
                endcase
            end
        end

        if (start_en) begin
            op       = op_at(n_stage, n_cmd);
            n_bit    = 3'd0;
            n_shift  = op.val;
            enter_en = 1'b1;
            unique case (op.kind)
                bbi2c_pkg::OP_START: enter_seg = bbi2c_pkg::SEG_START;
                bbi2c_pkg::OP_SEND:  enter_seg = bbi2c_pkg::SEG_SEND;
                bbi2c_pkg::OP_RECV:  enter_seg = bbi2c_pkg::SEG_RECV;
                default:             enter_seg = bbi2c_pkg::SEG_STOP;
            endcase
        end else begin
            op = '0;
        end

        ent_d = bbi2c_pkg::seg_table(enter_seg);
        sda   = n_pins.sda;
        unique case (ent_d.sda_mode)
            bbi2c_pkg::SDA_LOW:  sda = 1'b0;
            bbi2c_pkg::SDA_HIGH: sda = 1'b1;
            bbi2c_pkg::SDA_BIT:  sda = (n_shift & bbi2c_pkg::MSB_MASK) != 8'h00;
            // master ACKs the first read byte only when a second follows
            bbi2c_pkg::SDA_MACK: sda = !(n_stage == bbi2c_pkg::STG_RD_BYTE0 && n_cmd.two);
            default:             sda = n_pins.sda;
        endcase
        if (enter_en) begin
            n_step = enter_seg;
            n_wait = '0;
            n_pins = '{drv: ent_d.drv, sda: sda, scl: ent_d.scl};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= bbi2c_pkg::UNIT_W'(1);
        end else if (i_cfg_we) begin
            r_unit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in <= i_cmd.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res.scl        <= n_pins.scl;
            r_res.sda_out    <= n_pins.sda;
            r_res.sda_drive  <= n_pins.drv;
            r_res.busy_res   <= n_step != bbi2c_pkg::SEG_IDLE;
            r_res.done_res   <= n_done;
            r_res.nack_error <= n_err;
            r_res.read_bytes <= n_captured;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= bbi2c_pkg::SEG_IDLE;
            r_wait     <= '0;
            r_bit      <= '0;
            r_stage    <= '0;
            r_shift    <= '0;
            r_captured <= '0;
            r_pins     <= '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
        end else if (advance) begin
            r_step     <= n_step;
            r_wait     <= n_wait;
            r_bit      <= n_bit;
            r_stage    <= n_stage;
            r_shift    <= n_shift;
            r_captured <= n_captured;
            r_pins     <= n_pins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_cmd <= n_cmd;
        end
    end

    // a finished transaction leaves the sequencer idle
    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_done |=> r_step == bbi2c_pkg::SEG_IDLE)
        else $error("sequencer not idle after done");

    // busy and done never appear together on a result
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.done_res && r_res.busy_res))
        else $error("done raised while busy");

    // an error flag only comes with done
    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.nack_error |-> r_res.done_res)
        else $error("nack_error without done");

    // sequencer never leaves the segment table
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= bbi2c_pkg::SEG_STOP_END)
        else $error("sequencer step out of range");

endmodule
